### rtl/arb_pkg.sv
// Shared constants, codes and types for the audio ring buffer.
package arb_pkg;

  localparam int DEPTH   = 1024;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int FIELD_W = 10;
  localparam int CNT_W   = 32;
  localparam int SMP_W   = 32;
  // wide enough to compare pointer-sized levels with 10-bit fields
  localparam int LVL_W   = ((PTR_W > FIELD_W) ? PTR_W : FIELD_W) + 1;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_REALIGN = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    logic               from_ram;
    logic               read_valid;
    logic               write_accepted;
    logic [FIELD_W-1:0] fill_level;
    logic               read_ready;
    logic [CNT_W-1:0]   overrun_since_realign;
    logic [CNT_W-1:0]   overrun_total;
    logic [CNT_W-1:0]   realign_count;
    logic [FIELD_W-1:0] reference_fill;
    logic [CNT_W-1:0]   written_since_realign;
    logic [CNT_W-1:0]   read_since_realign;
  } res_t;

endpackage

### rtl/arb_if.sv
// Valid/ready channel interfaces for operation words and result words.
interface arb_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [arb_pkg::SMP_W-1:0]     sample;
  logic                          burst_end;
  logic [arb_pkg::FIELD_W-1:0]   target_fill;

  modport source (output valid, output operation, output sample, output burst_end,
                  output target_fill, input ready);
  modport sink   (input valid, input operation, input sample, input burst_end,
                  input target_fill, output ready);
endinterface

interface arb_out_if;
  logic                          valid;
  logic                          ready;
  logic [arb_pkg::SMP_W-1:0]     read_data;
  logic                          read_valid;
  logic                          write_accepted;
  logic [arb_pkg::FIELD_W-1:0]   fill_level;
  logic                          read_ready;
  logic [arb_pkg::CNT_W-1:0]     overrun_since_realign;
  logic [arb_pkg::CNT_W-1:0]     overrun_total;
  logic [arb_pkg::CNT_W-1:0]     realign_count;
  logic [arb_pkg::FIELD_W-1:0]   reference_fill;
  logic [arb_pkg::CNT_W-1:0]     written_since_realign;
  logic [arb_pkg::CNT_W-1:0]     read_since_realign;

  modport source (output valid, output read_data, output read_valid, output write_accepted,
                  output fill_level, output read_ready, output overrun_since_realign,
                  output overrun_total, output realign_count, output reference_fill,
                  output written_since_realign, output read_since_realign, input ready);
  modport sink   (input valid, input read_data, input read_valid, input write_accepted,
                  input fill_level, input read_ready, input overrun_since_realign,
                  input overrun_total, input realign_count, input reference_fill,
                  input written_since_realign, input read_since_realign, output ready);
endinterface

### rtl/audio_ring_buffer_realign.sv
// Audio sample ring buffer with overrun tracking, read-ready flag and realign.
// An accepted operation word's result is registered in stage one, then in the output register.
// Throughput: one operation word per cycle while dout.ready does not stall the result path;
// pointer and counter updates are single-pass. The sample store read port is registered;
// its data meets the result in the output register. Reset (rst, synchronous): pointers,
// counters, flags, threshold and valids clear; the sample store is not cleared and unwritten entries are never read.
module audio_ring_buffer_realign (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [arb_pkg::FIELD_W-1:0] cfg_wdata,
  arb_in_if.sink                      din,
  arb_out_if.source                   dout
);

  localparam int PW = arb_pkg::PTR_W;
  localparam int LW = arb_pkg::LVL_W;

  logic [PW-1:0]                 wp, wp_next;
  logic [PW-1:0]                 rp, rp_next;
  logic [PW-1:0]                 pad, pad_next;
  logic [PW-1:0]                 ref_level, ref_level_next;
  logic [arb_pkg::CNT_W-1:0]     ovr_recent, ovr_recent_next;
  logic [arb_pkg::CNT_W-1:0]     ovr_all, ovr_all_next;
  logic [arb_pkg::CNT_W-1:0]     realigns, realigns_next;
  logic [arb_pkg::CNT_W-1:0]     written_count, written_count_next;
  logic [arb_pkg::CNT_W-1:0]     read_count, read_count_next;
  logic                          ready_flag, ready_flag_next;
  logic                          burst_dropped, burst_dropped_next;
  logic [arb_pkg::FIELD_W-1:0]   read_threshold;

  logic                          accept;
  logic [PW-1:0]                 fill, fill_after, tgt, drop;
  logic                          ram_we, ram_re;
  logic [arb_pkg::SMP_W-1:0]     ram_q;
  logic                          write_ok, read_ok;
  arb_pkg::op_t                  op;

  logic                          s1_valid;
  logic                          s1_move;
  arb_pkg::res_t                 s1_res, s1_res_next;
  logic                          out_valid;
  arb_pkg::res_t                 out_res;
  logic [arb_pkg::SMP_W-1:0]     out_data;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(arb_pkg::DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_sub(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [LW-1:0] w;
    w = (a >= b) ? LW'(a) - LW'(b) : LW'(a) + LW'(arb_pkg::DEPTH) - LW'(b);
    ptr_sub = w[PW-1:0];
  endfunction

  assign op       = arb_pkg::op_t'(din.operation);
  assign s1_move  = s1_valid && (!out_valid || dout.ready);
  assign din.ready = !s1_valid || s1_move;
  assign accept   = din.valid && din.ready;

  assign fill     = ptr_sub(wp, rp);
  assign write_ok = (LW'(fill) < LW'(arb_pkg::DEPTH - 1));
  assign read_ok  = (fill != '0);
  assign tgt      = (LW'(din.target_fill) > LW'(arb_pkg::DEPTH - 1)) ?
                    PW'(arb_pkg::DEPTH - 1) : PW'(din.target_fill);
  assign drop     = fill - tgt;
  assign ram_we   = accept && (op == arb_pkg::OP_WRITE) && write_ok;
  assign ram_re   = accept && (op == arb_pkg::OP_READ) && read_ok && (pad == '0);

  always_comb begin
    wp_next            = wp;
    rp_next            = rp;
    pad_next           = pad;
    ref_level_next     = ref_level;
    ovr_recent_next    = ovr_recent;
    ovr_all_next       = ovr_all;
    realigns_next      = realigns;
    written_count_next = written_count;
    read_count_next    = read_count;
    ready_flag_next    = ready_flag;
    burst_dropped_next = burst_dropped;
    fill_after         = fill;
    s1_res_next        = '0;
    case (op)
      arb_pkg::OP_WRITE: begin
        if (write_ok) begin
          wp_next            = ptr_inc(wp);
          written_count_next = written_count + 1'b1;
          fill_after         = fill + PW'(1);
          s1_res_next.write_accepted = 1'b1;
        end else begin
          burst_dropped_next = 1'b1;
        end
        // close the burst: overrun, reference and threshold checks
        if (din.burst_end) begin
          if (burst_dropped_next) begin
            ovr_recent_next = ovr_recent + 1'b1;
            ovr_all_next    = ovr_all + 1'b1;
          end
          burst_dropped_next = 1'b0;
          if (ref_level == '0) begin
            ref_level_next = fill_after;
          end
          if (LW'(fill_after) >= LW'(read_threshold)) begin
            ready_flag_next = 1'b1;
          end
        end
      end
      arb_pkg::OP_READ: begin
        if (read_ok) begin
          if (pad != '0) begin
            pad_next = pad - PW'(1);
          end else begin
            s1_res_next.from_ram = 1'b1;
          end
          s1_res_next.read_valid = 1'b1;
          rp_next         = ptr_inc(rp);
          read_count_next = read_count + 1'b1;
          fill_after      = fill - PW'(1);
        end
      end
      arb_pkg::OP_REALIGN: begin
        if (fill < tgt) begin
          pad_next = pad + (tgt - fill);
        end else begin
          pad_next = (pad > drop) ? pad - drop : '0;
        end
        rp_next            = ptr_sub(wp, tgt);
        fill_after         = tgt;
        ref_level_next     = '0;
        ovr_recent_next    = '0;
        realigns_next      = realigns + 1'b1;
        ready_flag_next    = 1'b0;
        written_count_next = '0;
        read_count_next    = '0;
      end
      default: begin
      end
    endcase
    s1_res_next.fill_level            = arb_pkg::FIELD_W'(fill_after);
    s1_res_next.read_ready            = ready_flag_next;
    s1_res_next.overrun_since_realign = ovr_recent_next;
    s1_res_next.overrun_total         = ovr_all_next;
    s1_res_next.realign_count         = realigns_next;
    s1_res_next.reference_fill        = arb_pkg::FIELD_W'(ref_level_next);
    s1_res_next.written_since_realign = written_count_next;
    s1_res_next.read_since_realign    = read_count_next;
  end

  arb_ram #(
    .WIDTH (arb_pkg::SMP_W),
    .DEPTH (arb_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (din.sample),
    .re    (ram_re),
    .raddr (rp),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wp             <= '0;
      rp             <= '0;
      pad            <= '0;
      ref_level      <= '0;
      ovr_recent     <= '0;
      ovr_all        <= '0;
      realigns       <= '0;
      written_count  <= '0;
      read_count     <= '0;
      ready_flag     <= 1'b0;
      burst_dropped  <= 1'b0;
      read_threshold <= '0;
    end else begin
      if (cfg_we) begin
        read_threshold <= cfg_wdata;
      end
      if (accept) begin
        wp            <= wp_next;
        rp            <= rp_next;
        pad           <= pad_next;
        ref_level     <= ref_level_next;
        ovr_recent    <= ovr_recent_next;
        ovr_all       <= ovr_all_next;
        realigns      <= realigns_next;
        written_count <= written_count_next;
        read_count    <= read_count_next;
        ready_flag    <= ready_flag_next;
        burst_dropped <= burst_dropped_next;
      end
    end
  end

  // hold the store read data in stage one until the word moves to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= s1_res_next;
    end
    if (s1_move) begin
      out_res  <= s1_res;
      out_data <= s1_res.from_ram ? ram_q : '0;
    end
  end

  assign dout.valid                 = out_valid;
  assign dout.read_data             = out_data;
  assign dout.read_valid            = out_res.read_valid;
  assign dout.write_accepted        = out_res.write_accepted;
  assign dout.fill_level            = out_res.fill_level;
  assign dout.read_ready            = out_res.read_ready;
  assign dout.overrun_since_realign = out_res.overrun_since_realign;
  assign dout.overrun_total         = out_res.overrun_total;
  assign dout.realign_count         = out_res.realign_count;
  assign dout.reference_fill        = out_res.reference_fill;
  assign dout.written_since_realign = out_res.written_since_realign;
  assign dout.read_since_realign    = out_res.read_since_realign;

endmodule

### rtl/arb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/arb_checker.sv
// Port-level checks for the audio ring buffer, bound to the top level.
module arb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [arb_pkg::SMP_W-1:0]   read_data,
  input logic                        read_valid,
  input logic                        write_accepted,
  input logic [arb_pkg::FIELD_W-1:0] fill_level
);

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, fill_level} <= (arb_pkg::FIELD_W + 1)'(arb_pkg::DEPTH - 1)))
    else $error("fill level above depth minus one");

  a_read_or_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(read_valid && write_accepted))
    else $error("word shows both a read and a stored write");

  a_no_data_without_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !read_valid) |-> (read_data == '0))
    else $error("read data nonzero on a word without a read");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(read_data) && $stable(fill_level)))
    else $error("stalled result word changed");

endmodule

bind audio_ring_buffer_realign arb_checker u_arb_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (dout.valid),
  .out_ready      (dout.ready),
  .read_data      (dout.read_data),
  .read_valid     (dout.read_valid),
  .write_accepted (dout.write_accepted),
  .fill_level     (dout.fill_level)
);
